// ===== rtl/phcf_pkg.sv =====
// ----------------------------------------------------------------------------
// phcf_pkg
// Shared constants and item types of the peak-hold channel framer.
// ----------------------------------------------------------------------------
package phcf_pkg;

   localparam int CHANNELS  = 12;
   localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W     = $clog2(CHANNELS + 1);
   localparam int HIHAT_CH  = 10;
   localparam int SWITCH_CH = 11;
   localparam bit HAS_HIHAT  = (CHANNELS > HIHAT_CH);
   localparam bit HAS_SWITCH = (CHANNELS > SWITCH_CH);

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TX     = 1'b1;

   localparam logic [7:0] BYTE_MAX    = 8'd255;
   localparam logic [7:0] BYTE_MARKER = 8'd0;
   localparam logic [7:0] BYTE_MIN    = 8'd1;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_AW    = $clog2(RSP_DEPTH);

   typedef struct packed {
      logic       opcode;
      logic [3:0] channel;
      logic [9:0] sample;
      logic [2:0] switch_pins;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_start;
      logic       frame_end;
   } rsp_type;

endpackage

// ===== rtl/phcf_req_if.sv =====
// ----------------------------------------------------------------------------
// phcf_req_if
// Input item channel: valid/ready handshake with a request payload.
// ----------------------------------------------------------------------------
interface phcf_req_if;
   logic              valid;
   logic              ready;
   phcf_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/phcf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// phcf_rsp_if
// Result item channel: valid/ready handshake with a transmit byte payload.
// ----------------------------------------------------------------------------
interface phcf_rsp_if;
   logic              valid;
   logic              ready;
   phcf_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/peak_hold_channel_framer.sv =====
// ----------------------------------------------------------------------------
// peak_hold_channel_framer
// Per-channel peak-hold byte store with a serial frame output: a zero
// marker followed by every stored channel byte, each cleared once sent.
// ----------------------------------------------------------------------------
//  channel    direction  role
//  req_chan   in         sample update or transmit-ready item
//  rsp_chan   out        frame byte, one per transmit-ready item
//
//  One item per cycle while req ready is high. The byte store is a memory
//  read at accept and written back in the cycle after; a same-entry
//  follow-up is forwarded. A result passes stage 1 into the 4-entry
//  output queue. Synchronous reset clears valid bits, send position
//  and the queue. req ready drops while the queue plus the in-flight
//  result hold more than two items.
// ----------------------------------------------------------------------------
module peak_hold_channel_framer (
   input logic         clock,
   input logic         reset,
   phcf_req_if.sink    req_chan,
   phcf_rsp_if.source  rsp_chan
);
   import phcf_pkg::*;

   // byte store
   logic [7:0]          mem [CHANNELS];
   logic [CHANNELS-1:0] vld_ff;
   logic [7:0]          rd_data_ff;
   logic                rd_vld_ff;
   logic                fwd_ff;
   logic [7:0]          fwd_data_ff;

   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic [POS_W-1:0]    pos_dec;

   // stage 1
   logic                s1_vld_ff;
   logic                s1_tx_ff;
   logic                s1_marker_ff;
   logic                s1_last_ff;
   logic                s1_hihat_ff;
   logic                s1_switch_ff;
   logic [CH_AW-1:0]    s1_addr_ff;
   logic [9:0]          s1_sample_ff;
   logic [2:0]          s1_pins_ff;

   // output queue
   rsp_type             q_ff [RSP_DEPTH];
   logic [RSP_AW-1:0]   q_wr_ff;
   logic [RSP_AW-1:0]   q_rd_ff;
   logic [RSP_AW:0]     q_cnt_ff;
   logic [RSP_AW:0]     q_cnt_in;

   logic                accept;
   logic                is_tx;
   logic                in_range;
   logic [CH_AW-1:0]    rd_addr;
   logic [7:0]          old_byte;
   logic [7:0]          new_byte;
   logic [7:0]          sat_byte;
   logic [7:0]          hh_byte;
   logic                s1_we;
   logic                q_push;
   logic                q_pop;
   rsp_type             s1_rsp;

   assign accept   = req_chan.valid && req_chan.ready;
   assign is_tx    = (req_chan.payload.opcode == OP_TX);
   assign in_range = ({1'b0, req_chan.payload.channel} < 5'(CHANNELS));
   assign pos_dec  = pos_ff - POS_W'(1);
   assign rd_addr  = is_tx ? pos_dec[CH_AW-1:0] : req_chan.payload.channel[CH_AW-1:0];

   // hold intake while queue plus the result in stage 1 could overflow
   assign req_chan.ready = ((q_cnt_ff + (RSP_AW+1)'(s1_vld_ff && s1_tx_ff))
                            <= (RSP_AW+1)'(RSP_DEPTH - 2));

   always_comb begin
      pos_in = pos_ff;
      if (accept && is_tx) begin
         if (pos_ff == '0) begin
            pos_in = POS_W'(1);
         end else if (pos_ff >= POS_W'(CHANNELS)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   // modify stage
   always_comb begin
      old_byte = fwd_ff ? fwd_data_ff : (rd_vld_ff ? rd_data_ff : 8'd0);
      sat_byte = (s1_sample_ff[9:8] != 2'b00) ? BYTE_MAX : s1_sample_ff[7:0];
      if (sat_byte == 8'd0) begin
         sat_byte = BYTE_MIN;
      end
      hh_byte = s1_sample_ff[9:2];
      if (hh_byte == 8'd0) begin
         hh_byte = BYTE_MIN;
      end
      if (s1_tx_ff) begin
         new_byte = 8'd0;
      end else if (s1_hihat_ff) begin
         new_byte = hh_byte;
      end else if (s1_switch_ff) begin
         new_byte = {4'b0000, ~s1_pins_ff, 1'b1};
      end else begin
         new_byte = (sat_byte > old_byte) ? sat_byte : old_byte;
      end
      s1_we = s1_vld_ff && !s1_marker_ff;

      s1_rsp.tx_byte     = s1_marker_ff ? BYTE_MARKER : old_byte;
      s1_rsp.frame_start = s1_marker_ff;
      s1_rsp.frame_end   = s1_last_ff;
   end

   assign q_push   = s1_vld_ff && s1_tx_ff;
   assign q_pop    = rsp_chan.valid && rsp_chan.ready;
   assign q_cnt_in = q_cnt_ff + (RSP_AW+1)'(q_push) - (RSP_AW+1)'(q_pop);

   assign rsp_chan.valid   = (q_cnt_ff != '0);
   assign rsp_chan.payload = q_ff[q_rd_ff];

   // memory port: registered read, write back from stage 1
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (s1_we) begin
         mem[s1_addr_ff] <= new_byte;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= new_byte;
      rd_vld_ff   <= vld_ff[rd_addr];
      if (q_push) begin
         q_ff[q_wr_ff] <= s1_rsp;
      end
      s1_tx_ff     <= is_tx;
      s1_marker_ff <= is_tx && (pos_ff == '0);
      s1_last_ff   <= is_tx && (pos_ff == POS_W'(CHANNELS));
      s1_hihat_ff  <= HAS_HIHAT && (req_chan.payload.channel == 4'(HIHAT_CH));
      s1_switch_ff <= HAS_SWITCH && (req_chan.payload.channel == 4'(SWITCH_CH));
      s1_addr_ff   <= rd_addr;
      s1_sample_ff <= req_chan.payload.sample;
      s1_pins_ff   <= req_chan.payload.switch_pins;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         fwd_ff    <= 1'b0;
         pos_ff    <= '0;
         s1_vld_ff <= 1'b0;
         q_wr_ff   <= '0;
         q_rd_ff   <= '0;
         q_cnt_ff  <= '0;
      end else begin
         if (s1_we) begin
            vld_ff[s1_addr_ff] <= 1'b1;
         end
         // forward the write-back when the next read hits the same entry
         fwd_ff    <= s1_we && (s1_addr_ff == rd_addr);
         pos_ff    <= pos_in;
         s1_vld_ff <= accept && (is_tx || in_range);
         if (q_push) begin
            q_wr_ff <= q_wr_ff + RSP_AW'(1);
         end
         if (q_pop) begin
            q_rd_ff <= q_rd_ff + RSP_AW'(1);
         end
         q_cnt_ff <= q_cnt_in;
      end
   end

endmodule
